/* rtl/interrupt_latency_monitor_unit_assert.svh */
// Assertion macros shared by the interrupt latency monitor RTL.
// Included by file name from rtl/; no other dependencies.
`ifndef INTERRUPT_LATENCY_MONITOR_UNIT_ASSERT_SVH
`define INTERRUPT_LATENCY_MONITOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Plain property, checked outside reset.
`define ILM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);
// Same-cycle implication, checked outside reset.
`define ILM_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
`else
`define ILM_ASSERT(label, clk, rst, prop, msg)
`define ILM_ASSERT_IMPL(label, clk, rst, cond, prop, msg)
`endif
`endif

/* rtl/ilm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the interrupt latency monitor.
// No dependencies; imported by every module of the block.
package ilm_pkg;

  localparam int VECTOR_COUNT_DEF    = 16;
  localparam int PROCESSOR_COUNT_DEF = 8;

  // register map
  localparam logic REG_MIN_LATENCY   = 1'b0;
  localparam logic REG_TARGET_PROC   = 1'b1;
  localparam logic [63:0] MIN_LATENCY_RESET = 64'd10000;
  localparam logic [6:0]  TARGET_ALL        = 7'h7F;  // -1: every processor

  localparam logic STAGE_DELAY   = 1'b0;
  localparam logic STAGE_RUNTIME = 1'b1;

  // constant divider: x / 1000 = ((x >> 3) * RECIP) >> 68, RECIP = ceil(2^68 / 125),
  // built from four 32x32 partial products, one per cycle
  localparam logic [31:0] RECIP_LO = 32'hE353_F7CF;
  localparam logic [31:0] RECIP_HI = 32'h20C4_9BA5;
  localparam int DIV_STEPS = 4;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // decoupling queue, power of two deep
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_RAISE = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EXIT  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  vector;
    logic [5:0]  processor;
    logic [63:0] time_ns;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_DIVIDE,
    ST_REPORT
  } back_state_t;

endpackage

/* rtl/ilm_front.sv */
`timescale 1ns / 1ps
`include "interrupt_latency_monitor_unit_assert.svh"
// Front end: takes event beats, drops those that do not apply, queues the rest.
// Depends on ilm_pkg and the assertion header.
module ilm_front #(
  parameter int VECTOR_COUNT    = ilm_pkg::VECTOR_COUNT_DEF,
  parameter int PROCESSOR_COUNT = ilm_pkg::PROCESSOR_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          kind,
  input  logic [7:0]          vector,
  input  logic [5:0]          processor,
  input  logic [63:0]         time_ns,
  input  logic [6:0]          target_processor,
  input  logic                clearing,
  output ilm_pkg::head_t      head,
  input  logic                head_pop
);
  import ilm_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              accept;
  logic              pass;
  logic              kind_ok;
  logic              range_ok;
  logic              filter_ok;
  logic              enq;
  logic              deq;

  assign full = (count == QCNT_W'(QUEUE_DEPTH)) || clearing;
  assign accept = push && !full;

  assign kind_ok = (kind == KIND_RAISE) || (kind == KIND_ENTRY) || (kind == KIND_EXIT);
  assign range_ok = ({1'b0, vector} < 9'(VECTOR_COUNT)) &&
                    ({1'b0, processor} < 7'(PROCESSOR_COUNT));
  // negative target accepts everything
  assign filter_ok = target_processor[6] || (target_processor == {1'b0, processor});
  assign pass = kind_ok && range_ok && filter_ok;

  assign enq = accept && pass;
  assign deq = head_pop && (count != '0);

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= '{kind: kind_t'(kind), vector: vector,
                         processor: processor, time_ns: time_ns};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) wr_ptr <= wr_ptr + 1'b1;
      if (deq) rd_ptr <= rd_ptr + 1'b1;
      unique case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  `ILM_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ILM_ASSERT(a_drop_no_entry, clk, rst,
              (accept && !pass && !deq) |=> (count == $past(count)),
              "dropped beat changed queue fill")

endmodule

/* rtl/ilm_div.sv */
`timescale 1ns / 1ps
// Divide of a 64-bit value by 1000 through a reciprocal multiply, one 32x32
// partial product per cycle. Depends on ilm_pkg.
module ilm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  output logic        busy,
  output logic        done,
  output logic [63:0] quotient
);
  import ilm_pkg::*;

  logic [60:0]       operand;   // dividend >> 3
  logic [63:0]       acc;       // partial sum; settled low words are shifted out
  logic [DCNT_W-1:0] cnt;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       product;
  logic [63:0]       acc_next;

  assign product = {32'b0, mul_a} * {32'b0, mul_b};

  // low x low, low x high, high x low, high x high; the sum stays below 2^64
  always_comb begin
    mul_a    = operand[31:0];
    mul_b    = RECIP_LO;
    acc_next = acc;
    unique case (cnt)
      DCNT_W'(0): begin
        acc_next = product;
      end
      DCNT_W'(1): begin
        mul_b    = RECIP_HI;
        acc_next = {32'b0, acc[63:32]} + product;
      end
      DCNT_W'(2): begin
        mul_a    = {3'b000, operand[60:32]};
        acc_next = acc + product;
      end
      DCNT_W'(3): begin
        mul_a    = {3'b000, operand[60:32]};
        mul_b    = RECIP_HI;
        acc_next = {32'b0, acc[63:32]} + product;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      operand <= dividend[63:3];
      acc     <= '0;
    end else if (busy) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // acc holds (operand * RECIP) >> 64; four more bits of shift finish it
  assign quotient = {4'b0, acc[63:4]};

endmodule

/* rtl/ilm_back.sv */
`timescale 1ns / 1ps
`include "interrupt_latency_monitor_unit_assert.svh"
// Back end: stamp tables, read-modify-write sequencer, divide and report register.
// Depends on ilm_pkg, ilm_div and the assertion header.
module ilm_back #(
  parameter int VECTOR_COUNT    = ilm_pkg::VECTOR_COUNT_DEF,
  parameter int PROCESSOR_COUNT = ilm_pkg::PROCESSOR_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ilm_pkg::head_t head,
  output logic           head_pop,
  output logic           clearing,
  input  logic [63:0]    min_latency_us,
  output logic           empty,
  input  logic           pop,
  output logic           stage,
  output logic [7:0]     report_vector,
  output logic [5:0]     report_processor,
  output logic [63:0]    latency_us
);
  import ilm_pkg::*;

  localparam int DEPTH  = PROCESSOR_COUNT * VECTOR_COUNT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_t       state;
  back_state_t       state_next;
  item_t             cur;
  logic              cur_stage;
  logic              stage_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] waddr;

  logic [63:0] raise_mem [DEPTH];
  logic [63:0] entry_mem [DEPTH];
  logic [63:0] raise_rd;
  logic [63:0] entry_rd;
  logic        raise_we;
  logic        entry_we;
  logic [63:0] raise_wdata;
  logic [63:0] entry_wdata;

  logic        div_start;
  logic [63:0] diff;
  logic        div_busy;
  logic        div_done;
  logic [63:0] quotient;

  logic        out_valid;
  logic        out_free;
  logic        out_load;
  logic        over_min;

  assign addr  = ADDR_W'(int'(cur.processor) * VECTOR_COUNT + int'(cur.vector));
  assign waddr = (state == ST_CLEAR) ? clr_cnt : addr;

  always_ff @(posedge clk) begin
    if (raise_we) raise_mem[waddr] <= raise_wdata;
    if (entry_we) entry_mem[waddr] <= entry_wdata;
    raise_rd <= raise_mem[addr];
    entry_rd <= entry_mem[addr];
  end

  ilm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_free = !out_valid || pop;
  assign over_min = (quotient >= min_latency_us);
  assign clearing = (state == ST_CLEAR);

  always_comb begin
    state_next  = state;
    stage_next  = cur_stage;
    head_pop    = 1'b0;
    raise_we    = 1'b0;
    entry_we    = 1'b0;
    raise_wdata = '0;
    entry_wdata = '0;
    div_start   = 1'b0;
    diff        = '0;
    out_load    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        raise_we = 1'b1;
        entry_we = 1'b1;
        if (clr_cnt == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (head.valid) begin
          head_pop   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_MODIFY;
      ST_MODIFY: begin
        state_next = ST_IDLE;
        unique case (cur.kind)
          KIND_RAISE: begin
            if (raise_rd == '0) begin
              raise_we    = 1'b1;
              raise_wdata = cur.time_ns;
            end
          end
          KIND_ENTRY: begin
            entry_we    = 1'b1;
            entry_wdata = cur.time_ns;
            if (raise_rd != '0) begin
              raise_we   = 1'b1;
              diff       = cur.time_ns - raise_rd;
              div_start  = 1'b1;
              stage_next = STAGE_DELAY;
              state_next = ST_DIVIDE;
            end
          end
          KIND_EXIT: begin
            if (entry_rd != '0) begin
              entry_we   = 1'b1;
              diff       = cur.time_ns - entry_rd;
              div_start  = 1'b1;
              stage_next = STAGE_RUNTIME;
              state_next = ST_DIVIDE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DIVIDE: begin
        if (div_done) state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (!over_min) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) cur <= head.item;
    cur_stage <= stage_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      stage            <= cur_stage;
      report_vector    <= cur.vector;
      report_processor <= cur.processor;
      latency_us       <= quotient;
    end
  end

  assign empty = !out_valid;

  `ILM_ASSERT_IMPL(a_clear_quiet, clk, rst, state == ST_CLEAR, !out_valid && !head_pop,
                   "activity during table clear")
  `ILM_ASSERT_IMPL(a_load_threshold, clk, rst, out_load, over_min && out_free,
                   "report below threshold or over a waiting result")
  `ILM_ASSERT_IMPL(a_divide_live, clk, rst, state == ST_DIVIDE, div_busy || div_done,
                   "waiting on an idle divider")

endmodule

/* rtl/interrupt_latency_monitor_unit.sv */
`timescale 1ns / 1ps
// Top level of the interrupt latency monitor: config registers, front and back.
// Depends on ilm_pkg, ilm_front, ilm_back (and ilm_div below it).
//
// Interrupt latency monitor. Each input beat is one raise, handler entry or
// handler exit event for a (processor, vector) pair with a nanosecond stamp.
// An entry whose raise was seen yields a raise-to-entry delay (stage 0); an
// exit whose entry was seen yields the handler runtime (stage 1); both are
// in whole microseconds and are reported only at or above min_latency_us.
// Events of kind 3, out-of-range vectors or processors, and processors the
// target_processor filter rejects are taken and dropped. A stamp of zero
// marks an empty table slot, so an event at time zero leaves it empty.
// After reset the two stamp tables are cleared one slot per cycle, all
// PROCESSOR_COUNT * VECTOR_COUNT slots (128 by default), with full held
// high. After that an input beat enters a two-deep queue; dropped beats
// never reach the back end. The back end handles each event as a table
// read-modify-write through ST_IDLE, ST_READ and ST_MODIFY. An event that
// produces a measurement then runs the divide by 1000 (four multiply-add
// steps through one 32x32 multiplier) and a compare that loads the result
// register only at or above the threshold. The result register is a
// one-deep queue: the back end waits only when a report is ready and the
// previous one has not been popped. Configuration writes take effect on
// the next clock and are meant to be made while no event is in flight.
module interrupt_latency_monitor_unit #(
  parameter int VECTOR_COUNT    = ilm_pkg::VECTOR_COUNT_DEF,
  parameter int PROCESSOR_COUNT = ilm_pkg::PROCESSOR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // event input queue side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [7:0]  vector,
  input  logic [5:0]  processor,
  input  logic [63:0] time_ns,
  // report output queue side
  output logic        empty,
  input  logic        pop,
  output logic        stage,
  output logic [7:0]  report_vector,
  output logic [5:0]  report_processor,
  output logic [63:0] latency_us,
  // configuration write port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import ilm_pkg::*;

  logic [63:0] min_latency_us;
  logic [6:0]  target_processor;   // signed; bit 6 set accepts every processor
  head_t       head;
  logic        head_pop;
  logic        clearing;

  // Register file: two registers, indexed by their order in the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_latency_us   <= MIN_LATENCY_RESET;
      target_processor <= TARGET_ALL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_LATENCY: min_latency_us   <= cfg_data;
        REG_TARGET_PROC: target_processor <= cfg_data[6:0];
        default:         min_latency_us   <= min_latency_us;
      endcase
    end
  end

  // Front: filter and queue incoming beats.
  ilm_front #(
    .VECTOR_COUNT    (VECTOR_COUNT),
    .PROCESSOR_COUNT (PROCESSOR_COUNT)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .kind             (kind),
    .vector           (vector),
    .processor        (processor),
    .time_ns          (time_ns),
    .target_processor (target_processor),
    .clearing         (clearing),
    .head             (head),
    .head_pop         (head_pop)
  );

  // Back: tables, measurement, report register.
  ilm_back #(
    .VECTOR_COUNT    (VECTOR_COUNT),
    .PROCESSOR_COUNT (PROCESSOR_COUNT)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .head_pop         (head_pop),
    .clearing         (clearing),
    .min_latency_us   (min_latency_us),
    .empty            (empty),
    .pop              (pop),
    .stage            (stage),
    .report_vector    (report_vector),
    .report_processor (report_processor),
    .latency_us       (latency_us)
  );

endmodule

/* tb/sv/interrupt_latency_monitor_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for interrupt_latency_monitor_unit: directed table plus
// random raise/entry/exit sequences. Depends on ilm_pkg and the RTL top only.
module interrupt_latency_monitor_unit_test;
  import ilm_pkg::*;

  localparam int VEC_N = VECTOR_COUNT_DEF;
  localparam int PROC_N = PROCESSOR_COUNT_DEF;
  localparam logic [63:0] NS_PER_US = 64'd1000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;  // not decoded, always dropped
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;  // > one divide plus two queued beats
  localparam int HOLD_CYCLES = 300;

  // One latency report, laid out like the result ports.
  typedef struct packed {
    logic        stg;
    logic [7:0]  vec;
    logic [5:0]  proc;
    logic [63:0] lat;
  } latency_report_t;

  // Directed row: event fields, then an optional hand-written expectation.
  typedef struct packed {
    logic [1:0]  k;
    logic [7:0]  v;
    logic [5:0]  p;
    logic [63:0] t;
    bit          typed;
    bit          yields;
    logic        stg;
    logic [63:0] lat;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind = KIND_RAISE;
  logic [7:0]  vector = '0;
  logic [5:0]  processor = '0;
  logic [63:0] time_ns = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        stage;
  logic [7:0]  report_vector;
  logic [5:0]  report_processor;
  logic [63:0] latency_us;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_MIN_LATENCY;
  logic [63:0] cfg_data = '0;

  interrupt_latency_monitor_unit dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .kind(kind), .vector(vector), .processor(processor), .time_ns(time_ns),
    .empty(empty), .pop(pop),
    .stage(stage), .report_vector(report_vector),
    .report_processor(report_processor), .latency_us(latency_us),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bench copy of the block state: both stamp tables and the two registers.
  logic [63:0] raise_tbl [PROC_N][VEC_N];
  logic [63:0] entry_tbl [PROC_N][VEC_N];
  logic [63:0] min_reg;
  logic [6:0]  tgt_reg;

  latency_report_t awaited_reports [$];

  int errors = 0;
  int events_sent = 0;
  int events_taken = 0;     // reached the tables (filters passed, kind decoded)
  int reports_checked = 0;
  int settings_applied = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks = 0;        // bumped by the stimulus side to ask for a long hold
  int hold_seen = 0;
  int hold_left = 0;
  int unsigned cycles = 0;
  logic [63:0] wall_ns = 64'd1;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("ERROR: %s mismatch: got 0x%0h, expected 0x%0h (cycle %0d)",
             what, got, want, cycles);
    errors++;
  endtask

  // Applies one event to the bench state. Returns 1 when a report is due.
  function automatic bit track_event(input logic [1:0] k, input logic [7:0] v,
                                     input logic [5:0] p, input logic [63:0] t,
                                     output latency_report_t rep, output bit taken);
    logic [63:0] lat;
    bit hit;
    hit = 1'b0;
    taken = 1'b0;
    rep = '0;
    if (v >= VEC_N || p >= PROC_N) return 1'b0;
    // negative filter value (sign bit set) lets every processor through
    if (!tgt_reg[6] && tgt_reg[5:0] != p) return 1'b0;
    taken = 1'b1;
    case (k)
      KIND_RAISE: begin
        // first raise wins until an entry consumes it
        if (raise_tbl[p][v] == '0) raise_tbl[p][v] = t;
      end
      KIND_ENTRY: begin
        if (raise_tbl[p][v] != '0) begin
          lat = (t - raise_tbl[p][v]) / NS_PER_US;  // wraps mod 2^64
          raise_tbl[p][v] = '0;
          hit = (lat >= min_reg);
          rep = '{STAGE_DELAY, v, p, lat};
        end
        entry_tbl[p][v] = t;  // stamped even with no raise; zero stays empty
      end
      KIND_EXIT: begin
        if (entry_tbl[p][v] != '0) begin
          lat = (t - entry_tbl[p][v]) / NS_PER_US;
          entry_tbl[p][v] = '0;
          hit = (lat >= min_reg);
          rep = '{STAGE_RUNTIME, v, p, lat};
        end
      end
      default: taken = 1'b0;
    endcase
    return hit;
  endfunction

  // Offers one event beat and waits for it to be taken. push stays high on
  // return unless a random sender gap was inserted.
  task automatic send_event(input logic [1:0] k, input logic [7:0] v,
                            input logic [5:0] p, input logic [63:0] t,
                            output bit yields, output latency_report_t rep);
    bit taken;
    push <= 1'b1;
    kind <= k;
    vector <= v;
    processor <= p;
    time_ns <= t;
    do @(posedge clk); while (full !== 1'b0);
    yields = track_event(k, v, p, t, rep, taken);
    events_sent++;
    if (taken) events_taken++;
    // each sender cycle idles with the set chance
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic offer(input logic [1:0] k, input logic [7:0] v,
                       input logic [5:0] p, input logic [63:0] t);
    latency_report_t rep;
    bit yields;
    send_event(k, v, p, t, yields, rep);
    if (yields) awaited_reports.push_back(rep);
  endtask

  // One step of a raise/entry/exit sequence, sometimes broken on purpose.
  task automatic sequence_step(input logic [1:0] k, input logic [7:0] v,
                               input logic [5:0] p, input logic [63:0] t);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) offer(k, v, p, 64'd0);   // stamp of zero
    else if (roll >= 11) begin             // 3..10: step dropped
      offer(k, v, p, t);
      if (roll >= 94) offer(k, v, p, t + NS_PER_US);  // repeated event
    end
  endtask

  // Gap between events, scaled to the threshold so about half pass it.
  function automatic logic [63:0] pick_gap();
    logic [63:0] span;
    if ($urandom_range(0, 99) < 5) return {$urandom, $urandom};
    span = (min_reg > 64'd100000) ? 64'd100_000_000 : min_reg * NS_PER_US + NS_PER_US;
    return span * 64'($urandom_range(0, 200)) / 64'd100;
  endfunction

  // Stop offering, wait for every report, then let dropped beats drain.
  task automatic settle();
    push <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  task automatic apply_setting(input logic [63:0] min_us, input logic [63:0] target);
    cfg_write <= 1'b1;
    cfg_index <= REG_MIN_LATENCY;
    cfg_data <= min_us;
    @(posedge clk);
    min_reg = min_us;
    cfg_index <= REG_TARGET_PROC;
    cfg_data <= target;
    @(posedge clk);
    tgt_reg = target[6:0];
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // Random part: mostly whole sequences on one slot, some pure noise.
  task automatic run_phase(input int quota, input bit long_hold, input bit mid_drain);
    int first;
    int tries;
    bit held;
    bit drained;
    logic [7:0] v;
    logic [5:0] p;
    logic [63:0] t0;
    logic [63:0] d1;
    logic [63:0] d2;
    first = events_taken;
    tries = 0;
    held = 1'b0;
    drained = 1'b0;
    // tries cap keeps a filter that rejects everything from looping forever
    while (events_taken - first < quota && tries < 4 * quota) begin
      tries++;
      if (long_hold && !held && events_taken - first >= 60) begin
        held = 1'b1;
        hold_asks++;  // sink stops popping; input side must back up
      end
      if (mid_drain && !drained && events_taken - first >= quota / 2) begin
        drained = 1'b1;
        push <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 15) begin
        offer(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              6'($urandom_range(0, 63)), {$urandom, $urandom});
      end else begin
        if (!tgt_reg[6] && $urandom_range(0, 99) < 85) p = tgt_reg[5:0];
        else if ($urandom_range(0, 99) < 90) p = 6'($urandom_range(0, PROC_N - 1));
        else p = 6'($urandom_range(0, 63));
        v = ($urandom_range(0, 99) < 92) ? 8'($urandom_range(0, VEC_N - 1))
                                         : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 20) t0 = {$urandom, $urandom};
        else begin
          wall_ns += 64'($urandom_range(1, 1_000_000));
          t0 = wall_ns;
        end
        d1 = pick_gap();
        d2 = pick_gap();
        sequence_step(KIND_RAISE, v, p, t0);
        sequence_step(KIND_ENTRY, v, p, t0 + d1);
        sequence_step(KIND_EXIT, v, p, t0 + d1 + d2);
      end
    end
  endtask

  function automatic stim_row_t dir_row(logic [1:0] k, logic [7:0] v, logic [5:0] p,
                                        logic [63:0] t, bit typed, bit yields = 1'b0,
                                        logic stg = STAGE_DELAY, logic [63:0] lat = '0);
    return '{k, v, p, t, typed, yields, stg, lat};
  endfunction

  // Report sink: checks every popped beat against the oldest expectation,
  // then decides whether to pop next cycle (random idle or a long hold).
  always @(posedge clk) begin : report_sink
    latency_report_t want;
    if (!rst && pop && empty === 1'b0) begin
      if (awaited_reports.size() == 0) begin
        flag_mismatch("unexpected report, latency", latency_us, '0);
      end else begin
        want = awaited_reports.pop_front();
        reports_checked++;
        if (stage !== want.stg) flag_mismatch("stage", 64'(stage), 64'(want.stg));
        if (report_vector !== want.vec)
          flag_mismatch("vector", 64'(report_vector), 64'(want.vec));
        if (report_processor !== want.proc)
          flag_mismatch("processor", 64'(report_processor), 64'(want.proc));
        if (latency_us !== want.lat) flag_mismatch("latency", latency_us, want.lat);
      end
    end
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog; also covers a report that never shows up.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ERROR: cycle limit of %0d reached, %0d reports still pending",
               CYCLE_LIMIT, awaited_reports.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_tbl [$];
    stim_row_t row;
    latency_report_t rep;
    bit yields;

    foreach (raise_tbl[p, v]) begin
      raise_tbl[p][v] = '0;
      entry_tbl[p][v] = '0;
    end
    min_reg = MIN_LATENCY_RESET;
    tgt_reg = TARGET_ALL;

    // Directed rows run at the reset register values (10000 us, all
    // processors), so they also check those. Untyped rows go to the predictor.
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'd0, 6'd0, 64'd1000, 1'b1));
    // exactly at threshold
    dir_tbl.push_back(dir_row(KIND_ENTRY, 8'd0, 6'd0, 64'd10_001_000, 1'b1, 1'b1,
                              STAGE_DELAY, 64'd10000));
    // one ns short of threshold
    dir_tbl.push_back(dir_row(KIND_EXIT, 8'd0, 6'd0, 64'd20_000_999, 1'b1));
    // top corner slot, raise at all ones then entry after the counter wraps
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'd15, 6'd7, '1, 1'b1));
    dir_tbl.push_back(dir_row(KIND_ENTRY, 8'd15, 6'd7, 64'd9_999_999, 1'b1, 1'b1,
                              STAGE_DELAY, 64'd10000));
    dir_tbl.push_back(dir_row(KIND_EXIT, 8'd15, 6'd7, '1, 1'b0));
    // out-of-range vectors and processors are dropped
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'd16, 6'd0, 64'd5, 1'b1));
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'd255, 6'd63, 64'd5, 1'b1));
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'd3, 6'd8, 64'd5, 1'b1));
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'hAA, 6'h2A, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'h55, 6'h15, 64'h5555_5555_5555_5555, 1'b1));
    dir_tbl.push_back(dir_row(KIND_UNUSED, 8'd3, 6'd2, '1, 1'b1));
    // raise at time zero leaves the slot empty: entry measures nothing
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'd3, 6'd2, 64'd0, 1'b1));
    dir_tbl.push_back(dir_row(KIND_ENTRY, 8'd3, 6'd2, 64'd50_000_000, 1'b1));
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'd3, 6'd2, 64'd20_000_000, 1'b1));
    // second raise must not overwrite the first
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'd3, 6'd2, 64'd30_000_000, 1'b1));
    dir_tbl.push_back(dir_row(KIND_EXIT, 8'd3, 6'd2, 64'd80_000_000, 1'b1, 1'b1,
                              STAGE_RUNTIME, 64'd30000));
    // entry at zero: backwards difference, entry slot stays empty
    dir_tbl.push_back(dir_row(KIND_ENTRY, 8'd3, 6'd2, 64'd0, 1'b0));
    dir_tbl.push_back(dir_row(KIND_EXIT, 8'd3, 6'd2, 64'd100, 1'b1));
    // zero runtime, below threshold
    dir_tbl.push_back(dir_row(KIND_ENTRY, 8'd5, 6'd1, 64'd12345, 1'b1));
    dir_tbl.push_back(dir_row(KIND_EXIT, 8'd5, 6'd1, 64'd12345, 1'b1));
    dir_tbl.push_back(dir_row(KIND_RAISE, 8'd1, 6'd4, 64'h8000_0000_0000_0000, 1'b1));
    dir_tbl.push_back(dir_row(KIND_ENTRY, 8'd1, 6'd4, 64'h8000_0100_0000_0000, 1'b0));
    dir_tbl.push_back(dir_row(KIND_EXIT, 8'd1, 6'd4, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0));

    // sender idles 23%, receiver 56%
    tx_idle_pct = 23;
    rx_idle_pct = 56;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // table clear after reset shows up as full; send_event waits it out
    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      send_event(row.k, row.v, row.p, row.t, yields, rep);
      if (row.typed) begin
        if (yields != row.yields)
          flag_mismatch("directed row report count", 64'(yields), 64'(row.yields));
        if (row.yields) awaited_reports.push_back('{row.stg, row.v, row.p, row.lat});
      end else if (yields) begin
        awaited_reports.push_back(rep);
      end
    end

    // threshold zero: every measurement reports
    settle();
    apply_setting(64'd0, '1);
    run_phase(285, 1'b0, 1'b0);

    // single processor; long sink stall backs up the input
    settle();
    apply_setting(MIN_LATENCY_RESET, 64'd3);
    run_phase(285, 1'b1, 1'b0);

    tx_idle_pct = 56;
    rx_idle_pct = 23;
    // max threshold: nothing may report; most negative filter accepts all
    settle();
    apply_setting('1, 64'hFFFF_FFFF_FFFF_FFC0);
    run_phase(285, 1'b0, 1'b0);

    // lowest processor, random small threshold; sender drains halfway
    settle();
    apply_setting(64'($urandom_range(1, 5000)), 64'd0);
    run_phase(285, 1'b0, 1'b1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    settle();
    apply_setting(64'd7, 64'd7);
    run_phase(285, 1'b0, 1'b0);

    // filter at its top value names a processor that does not exist
    settle();
    apply_setting(64'd50, 64'd63);
    run_phase(10, 1'b0, 1'b0);

    settle();
    $display("Summary: %0d event beats sent, %0d reached the stamp tables, %0d reports checked",
             events_sent, events_taken, reports_checked);
    $display("Summary: %0d register settings after reset, %0d mismatches",
             settings_applied, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ilm_pkg.sv
rtl/ilm_front.sv
rtl/ilm_div.sv
rtl/ilm_back.sv
rtl/interrupt_latency_monitor_unit.sv
tb/sv/interrupt_latency_monitor_unit_test.sv
